@@ hdl/edsw_pkg.sv @@
package edsw_pkg;

  // Session codes carried in the result.
  localparam logic [1:0] SessUnknown = 2'd0;
  localparam logic [1:0] SessClosed  = 2'd1;
  localparam logic [1:0] SessOpen    = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgOpenMinute  = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgCloseMinute = 1'd1;

  localparam int unsigned MinW = 11;
  localparam logic [MinW-1:0] OpenReset  = 11'd570;
  localparam logic [MinW-1:0] CloseReset = 11'd960;
  localparam logic [MinW-1:0] MinPerDay  = 11'd1440;
  localparam logic [MinW-1:0] ShiftDst   = 11'd240;
  localparam logic [MinW-1:0] ShiftStd   = 11'd300;

  // Year arithmetic: the year plus one 400-year cycle fits in 13 bits.
  localparam int unsigned YearW  = 13;
  localparam logic [YearW-1:0] YearBias = 13'd400;
  // Reciprocal of 25 scaled by 2^20; exact for quotients of y/4 below 2^11.
  localparam int unsigned RecipShift = 20;
  localparam logic [15:0] Recip25    = 16'd41944;

  // Load enables for the two registered steps of the year key unit.
  typedef struct packed {
    logic ld1;
    logic ld2;
  } edsw_load_t;

  // Residue modulo 7 by folding octal digits (8 is 1 modulo 7).
  function automatic logic [2:0] mod7(input logic [13:0] v);
    logic [5:0] s1;
    logic [3:0] s2;
    s1 = {3'b0, v[2:0]} + {3'b0, v[5:3]} + {3'b0, v[8:6]} + {3'b0, v[11:9]}
         + {4'b0, v[13:12]};
    s2 = {1'b0, s1[5:3]} + {1'b0, s1[2:0]};
    if (s2 >= 4'd7) begin
      s2 = s2 - 4'd7;
    end
    return s2[2:0];
  endfunction

  // Month key of the weekday method; months out of range clamp to 1 or 12.
  function automatic logic [2:0] month_key(input logic [3:0] m);
    logic [2:0] k;
    case (m)
      4'd0, 4'd1: k = 3'd0;
      4'd2:       k = 3'd3;
      4'd3:       k = 3'd2;
      4'd4:       k = 3'd5;
      4'd5:       k = 3'd0;
      4'd6:       k = 3'd3;
      4'd7:       k = 3'd5;
      4'd8:       k = 3'd1;
      4'd9:       k = 3'd4;
      4'd10:      k = 3'd6;
      4'd11:      k = 3'd2;
      default:    k = 3'd4;
    endcase
    return k;
  endfunction

endpackage

@@ hdl/edsw_year_key.sv @@
module edsw_year_key
  import edsw_pkg::*;
(
  input  logic             clk_i,
  input  edsw_load_t       load_i,
  input  logic [YearW-1:0] year_i,
  output logic [2:0]       key_o
);

  logic [YearW-1:0] y_q;
  logic [10:0]      q_q;
  logic [26:0]      prod_q;
  logic [2:0]       key_q;
  logic [10:0]      q_d;
  logic [6:0]       cent;
  logic [13:0]      sum;

  // First step: y/4 and its product with the reciprocal of 25.
  assign q_d = year_i[YearW-1:2];

  always_ff @(posedge clk_i) begin
    if (load_i.ld1) begin
      y_q    <= year_i;
      q_q    <= q_d;
      prod_q <= {16'b0, q_d} * {11'b0, Recip25};
    end
  end

  // Second step: y + y/4 - y/100 + y/400, reduced modulo 7.
  assign cent = prod_q[RecipShift+6:RecipShift];
  assign sum  = {1'b0, y_q} + {3'b0, q_q} - {7'b0, cent} + {9'b0, cent[6:2]};

  always_ff @(posedge clk_i) begin
    if (load_i.ld2) begin
      key_q <= mod7(sum);
    end
  end

  assign key_o = key_q;

endmodule

@@ hdl/eastern_dst_session_window.sv @@
// US Eastern session window on a stream of UTC time samples.
// The slave stream carries one broken-down UTC date and time per transfer,
// with the clock-valid flag in tuser. The master stream returns one result
// per accepted sample: the session code (unknown, closed, open) and the
// Eastern daylight-time flag.
// The configuration channel writes the window bounds (open minute,
// inclusive, and close minute, exclusive) and is always ready; write it
// only while no sample is in flight.
// The datapath is a four-stage pipeline: two stages for the year keys of the
// weekday method (a reciprocal multiply, then the modulo-7 fold), one for the
// DST decision and the weekday, one for the local time shift and the window
// compare. One sample is accepted every cycle unless the stalled pipeline is full.
// Each stage has its own valid bit; when the receiver stalls, the stages
// behind the held result keep filling until every stage is full, and then
// tready drops. Nothing is lost or repeated.
// Reset empties the pipeline and restores the window to 570 and 960.
module eastern_dst_session_window
  import edsw_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write channel.
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [MinW-1:0]    cfg_data_i,
  // Input samples.
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // utc_year[11:0], utc_month[15:12], utc_day[20:16], utc_hour[25:21],
  // utc_minute[31:26]
  input  logic [31:0]        s_axis_tdata,
  // clock_valid[0]
  input  logic               s_axis_tuser,
  // Results.
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // session[1:0], dst_active[2], zero[7:3]
  output logic [7:0]         m_axis_tdata
);

  logic [MinW-1:0] open_q, close_q;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q  <= OpenReset;
      close_q <= CloseReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgOpenMinute:  open_q  <= cfg_data_i;
        CfgCloseMinute: close_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage handshake: a stage loads when it is empty or its successor loads.
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_q || m_axis_tready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign s_axis_tready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // Input field split and the front-end arithmetic.
  logic [11:0]      in_year;
  logic [3:0]       in_month;
  logic [4:0]       in_day, in_hour;
  logic [5:0]       in_minute;
  logic             early_month;
  logic [YearW-1:0] year_raw, year_adj;
  logic [MinW-1:0]  in_umin;
  logic [5:0]       in_dsum;

  assign in_year   = s_axis_tdata[11:0];
  assign in_month  = s_axis_tdata[15:12];
  assign in_day    = s_axis_tdata[20:16];
  assign in_hour   = s_axis_tdata[25:21];
  assign in_minute = s_axis_tdata[31:26];

  // January, February and the clamped month zero count in the prior year.
  assign early_month = (in_month < 4'd3);
  assign year_raw    = {1'b0, in_year} + YearBias;
  assign year_adj    = year_raw - {{(YearW-1){1'b0}}, early_month};
  assign in_umin     = {6'b0, in_hour} * 11'd60 + {5'b0, in_minute};
  assign in_dsum     = {3'b0, month_key(in_month)} + {1'b0, in_day};

  // Year keys: the year adjusted for January and February, and the unadjusted
  // year for March and November.
  edsw_load_t yk_load;
  logic [2:0] yk_raw, yk_adj;

  assign yk_load.ld1 = rdy1;
  assign yk_load.ld2 = rdy2;

  edsw_year_key u_key_raw (
    .clk_i  (clk_i),
    .load_i (yk_load),
    .year_i (year_raw),
    .key_o  (yk_raw)
  );

  edsw_year_key u_key_adj (
    .clk_i  (clk_i),
    .load_i (yk_load),
    .year_i (year_adj),
    .key_o  (yk_adj)
  );

  // Stage 1 and stage 2 side fields.
  logic            s1_ok_q, s2_ok_q;
  logic [3:0]      s1_mon_q, s2_mon_q;
  logic [4:0]      s1_day_q, s2_day_q, s1_hour_q, s2_hour_q;
  logic [MinW-1:0] s1_umin_q, s2_umin_q;
  logic [5:0]      s1_dsum_q, s2_dsum_q;

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      s1_ok_q   <= s_axis_tuser;
      s1_mon_q  <= in_month;
      s1_day_q  <= in_day;
      s1_hour_q <= in_hour;
      s1_umin_q <= in_umin;
      s1_dsum_q <= in_dsum;
    end
    if (rdy2) begin
      s2_ok_q   <= s1_ok_q;
      s2_mon_q  <= s1_mon_q;
      s2_day_q  <= s1_day_q;
      s2_hour_q <= s1_hour_q;
      s2_umin_q <= s1_umin_q;
      s2_dsum_q <= s1_dsum_q;
    end
  end

  // Stage 3: Sundays of March and November, DST state and UTC weekday.
  // March 1 and November 1 share a month key, so they share a weekday.
  logic [2:0]  first_wd;
  logic [4:0]  first_sun, start_day;
  logic [13:0] now_key, start_key, stop_key;
  logic        dst_d;
  logic [2:0]  wd_d;

  assign first_wd  = mod7({11'b0, yk_raw} + 14'd3);
  assign first_sun = (first_wd == 3'd0) ? 5'd1 : 5'd8 - {2'b0, first_wd};
  assign start_day = first_sun + 5'd7;
  assign now_key   = {s2_mon_q, s2_day_q, s2_hour_q};
  assign start_key = {4'd3, start_day, 5'd7};
  assign stop_key  = {4'd11, first_sun, 5'd6};
  assign dst_d     = (now_key >= start_key) && (now_key < stop_key);
  assign wd_d      = mod7({11'b0, yk_adj} + {8'b0, s2_dsum_q});

  logic            s3_ok_q, s3_dst_q;
  logic [2:0]      s3_wd_q;
  logic [MinW-1:0] s3_umin_q;

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      s3_ok_q   <= s2_ok_q;
      s3_dst_q  <= dst_d;
      s3_wd_q   <= wd_d;
      s3_umin_q <= s2_umin_q;
    end
  end

  // Stage 4: shift to local time, carry the weekday, compare to the window.
  logic [MinW-1:0] shift, local_min, late_min;
  logic [2:0]      local_wd;
  logic [1:0]      session_d;
  logic            dst_out_d;

  assign shift    = s3_dst_q ? ShiftDst : ShiftStd;
  assign late_min = s3_umin_q - shift;

  always_comb begin
    if (s3_umin_q < shift) begin
      local_min = s3_umin_q + MinPerDay - shift;
      local_wd  = (s3_wd_q == 3'd0) ? 3'd6 : s3_wd_q - 3'd1;
    end else if (late_min >= MinPerDay) begin
      local_min = late_min - MinPerDay;
      local_wd  = (s3_wd_q == 3'd6) ? 3'd0 : s3_wd_q + 3'd1;
    end else begin
      local_min = late_min;
      local_wd  = s3_wd_q;
    end
  end

  always_comb begin
    if (!s3_ok_q) begin
      session_d = SessUnknown;
      dst_out_d = 1'b0;
    end else begin
      dst_out_d = s3_dst_q;
      if (local_wd == 3'd0 || local_wd == 3'd6) begin
        session_d = SessClosed;
      end else if (local_min >= open_q && local_min < close_q) begin
        session_d = SessOpen;
      end else begin
        session_d = SessClosed;
      end
    end
  end

  logic [1:0] session_q;
  logic       dst_q;

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      session_q <= session_d;
      dst_q     <= dst_out_d;
    end
  end

  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = {5'b0, dst_q, session_q};

`ifndef ASSERT_OFF
  // An unknown clock never reports daylight time.
  a_unknown_no_dst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && session_q == SessUnknown) |-> !dst_q)
    else $error("dst_active set with unknown clock");

  // The session code is always one of the three defined codes.
  a_session_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (session_q == SessUnknown || session_q == SessClosed ||
                       session_q == SessOpen))
    else $error("undefined session code");

  // While the output is held, input is taken only if some stage is empty.
  a_stall_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tready && m_axis_tvalid && !m_axis_tready) |-> !(v1_q && v2_q && v3_q))
    else $error("input accepted into a full stalled pipeline");

  // A result in the last compute stage reaches the output when it can move.
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && rdy4) |=> v4_q)
    else $error("pipeline lost an item at the output stage");
`endif

endmodule
